// File: src/gcdisp_pkg.sv
// Shared types, constants and tables of the greedy change dispenser.
package gcdisp_pkg;

   // Widths
   localparam int COUNT_BITS  = 10;
   localparam int NUM_DENOMS  = 10;
   localparam int DENOM_BITS  = 4;
   localparam int LOAD_BITS   = 10;
   localparam int AMOUNT_BITS = 16;
   localparam int OUT_BITS    = 10;
   localparam int VALUE_BITS  = 13;
   localparam int RECIP_BITS  = 17;
   localparam int SHIFT_BITS  = 5;
   // largest fit is 65535 / 5 = 13107
   localparam int FIT_BITS    = 14;
   localparam int PROD1_BITS  = AMOUNT_BITS + RECIP_BITS;
   localparam int TAKE_BITS   = (COUNT_BITS < FIT_BITS) ? COUNT_BITS : FIT_BITS;
   localparam int MIN_BITS    = (COUNT_BITS > FIT_BITS) ? COUNT_BITS : FIT_BITS;
   localparam int PROD2_BITS  = TAKE_BITS + VALUE_BITS;
   localparam int LSAT_BITS   = (COUNT_BITS > LOAD_BITS) ? COUNT_BITS : LOAD_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [DENOM_BITS-1:0] LAST_DENOM = DENOM_BITS'(NUM_DENOMS - 1);

   // Denomination values in cents, lowest first
   localparam logic [VALUE_BITS-1:0] DENOM_VALUE [NUM_DENOMS] = '{
      13'd5, 13'd10, 13'd20, 13'd50, 13'd100,
      13'd200, 13'd500, 13'd1000, 13'd2000, 13'd5000
   };

   // floor(a / v) = (a * RECIP) >> SHIFT, exact for any 16-bit a;
   // RECIP = ceil(2^SHIFT / v), SHIFT = 16 + clog2(v)
   localparam logic [RECIP_BITS-1:0] DENOM_RECIP [NUM_DENOMS] = '{
      17'd104858, 17'd104858, 17'd104858, 17'd83887, 17'd83887,
      17'd83887, 17'd67109, 17'd67109, 17'd67109, 17'd107375
   };

   localparam logic [SHIFT_BITS-1:0] DENOM_SHIFT [NUM_DENOMS] = '{
      5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
      5'd24, 5'd25, 5'd26, 5'd27, 5'd29
   };

   typedef enum logic [1:0] {
      OP_SET      = 2'd0,
      OP_DEPOSIT  = 2'd1,
      OP_DISPENSE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SUB,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [1:0]             op;
      logic [DENOM_BITS-1:0]  denom_index;
      logic [LOAD_BITS-1:0]   load_count;
      logic [AMOUNT_BITS-1:0] change_cents;
   } req_word_type;

   typedef struct packed {
      logic                status;
      logic [OUT_BITS-1:0] five_cent_out;
      logic [OUT_BITS-1:0] ten_cent_out;
      logic [OUT_BITS-1:0] twenty_cent_out;
      logic [OUT_BITS-1:0] fifty_cent_out;
      logic [OUT_BITS-1:0] one_dollar_out;
      logic [OUT_BITS-1:0] two_dollar_out;
      logic [OUT_BITS-1:0] five_dollar_out;
      logic [OUT_BITS-1:0] ten_dollar_out;
      logic [OUT_BITS-1:0] twenty_dollar_out;
      logic [OUT_BITS-1:0] fifty_dollar_out;
   } rsp_word_type;

endpackage

// File: src/greedy_change_dispenser_top.sv
// Greedy change dispenser: stock of ten denominations, set/deposit/dispense.
//
// A request word is taken at a rising edge with start high and busy low.
// Set and deposit update the stock at that edge; their response (status 0,
// all counts 0) shows on the next cycle, and a new word may be taken in
// that same cycle, so these run one word per cycle.
// Dispense walks the denominations from $50 down to 5c, each in a DIV
// state, the reciprocal multiply that gives how many pieces fit, and a SUB
// state, the limit against stock and the multiply-subtract of the remainder.
// A COMMIT state then writes the stock back, or on a non-zero remainder
// leaves it untouched and flags failure. The response shows in the REPLY
// state after COMMIT; busy is high until then, so no new dispense word
// is taken before the last one is through.
// Each response is on rsp_word for exactly one cycle, marked by rsp_valid;
// the receiver cannot hold it off and must take it then.
// Reset clears all stock counts to zero and returns the sequencer to idle.
module greedy_change_dispenser_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  gcdisp_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   output gcdisp_pkg::rsp_word_type rsp_word
);

   gcdisp_pkg::state_type state_ff, state_in;

   logic [gcdisp_pkg::COUNT_BITS-1:0]  stock_ff [gcdisp_pkg::NUM_DENOMS];
   logic [gcdisp_pkg::COUNT_BITS-1:0]  stock_in [gcdisp_pkg::NUM_DENOMS];
   logic [gcdisp_pkg::TAKE_BITS-1:0]   take_ff  [gcdisp_pkg::NUM_DENOMS];
   logic [gcdisp_pkg::TAKE_BITS-1:0]   take_in  [gcdisp_pkg::NUM_DENOMS];
   logic [gcdisp_pkg::AMOUNT_BITS-1:0] amount_ff, amount_in;
   logic [gcdisp_pkg::FIT_BITS-1:0]    fit_ff, fit_in;
   logic [gcdisp_pkg::DENOM_BITS-1:0]  denom_ff, denom_in;
   logic                               status_ff, status_in;

   logic                               accept;
   logic [gcdisp_pkg::DENOM_BITS-1:0]  rd_idx;
   logic                               idx_ok;
   logic [gcdisp_pkg::COUNT_BITS-1:0]  stock_rd;
   logic [gcdisp_pkg::COUNT_BITS-1:0]  load_sat;
   logic [gcdisp_pkg::PROD1_BITS-1:0]  prod1;
   logic [gcdisp_pkg::PROD1_BITS-1:0]  quot;
   logic [gcdisp_pkg::MIN_BITS-1:0]    fit_ext, stock_ext;
   logic [gcdisp_pkg::TAKE_BITS-1:0]   take_n;
   logic [gcdisp_pkg::PROD2_BITS-1:0]  prod2;

   assign accept = start && !busy;

   // Single read port on the stock: request index at accept, walk index in SUB
   assign rd_idx   = (state_ff == gcdisp_pkg::ST_SUB) ? denom_ff : req_word.denom_index;
   assign idx_ok   = (rd_idx <= gcdisp_pkg::LAST_DENOM);
   assign stock_rd = idx_ok ? stock_ff[rd_idx] : '0;

   // Saturate load to the count range
   always_comb begin
      if (gcdisp_pkg::LSAT_BITS'(req_word.load_count) >
          gcdisp_pkg::LSAT_BITS'(gcdisp_pkg::COUNT_MAX)) begin
         load_sat = gcdisp_pkg::COUNT_MAX;
      end else begin
         load_sat = gcdisp_pkg::COUNT_BITS'(req_word.load_count);
      end
   end

   // Shared unit, DIV step: pieces that fit = amount * recip >> shift
   assign prod1 = gcdisp_pkg::PROD1_BITS'(amount_ff) *
                  gcdisp_pkg::PROD1_BITS'(gcdisp_pkg::DENOM_RECIP[denom_ff]);
   assign quot  = prod1 >> gcdisp_pkg::DENOM_SHIFT[denom_ff];

   // Shared unit, SUB step: limit by stock, then pieces * value
   assign fit_ext   = gcdisp_pkg::MIN_BITS'(fit_ff);
   assign stock_ext = gcdisp_pkg::MIN_BITS'(stock_rd);
   assign take_n    = (fit_ext < stock_ext) ? gcdisp_pkg::TAKE_BITS'(fit_ext)
                                            : gcdisp_pkg::TAKE_BITS'(stock_ext);
   assign prod2     = gcdisp_pkg::PROD2_BITS'(take_n) *
                      gcdisp_pkg::PROD2_BITS'(gcdisp_pkg::DENOM_VALUE[denom_ff]);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcdisp_pkg::ST_IDLE, gcdisp_pkg::ST_REPLY: begin
            if (accept) begin
               if (req_word.op == gcdisp_pkg::OP_DISPENSE) begin
                  state_in = gcdisp_pkg::ST_DIV;
               end else begin
                  state_in = gcdisp_pkg::ST_REPLY;
               end
            end else begin
               state_in = gcdisp_pkg::ST_IDLE;
            end
         end
         gcdisp_pkg::ST_DIV:    state_in = gcdisp_pkg::ST_SUB;
         gcdisp_pkg::ST_SUB: begin
            if (denom_ff == '0) begin
               state_in = gcdisp_pkg::ST_COMMIT;
            end else begin
               state_in = gcdisp_pkg::ST_DIV;
            end
         end
         gcdisp_pkg::ST_COMMIT: state_in = gcdisp_pkg::ST_REPLY;
         default:               state_in = gcdisp_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         gcdisp_pkg::ST_IDLE:  busy = 1'b0;
         gcdisp_pkg::ST_REPLY: begin
            busy      = 1'b0;
            rsp_valid = 1'b1;
         end
         default: begin
            busy      = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      stock_in  = stock_ff;
      take_in   = take_ff;
      amount_in = amount_ff;
      fit_in    = fit_ff;
      denom_in  = denom_ff;
      status_in = status_ff;
      if (accept) begin
         take_in   = '{default: '0};
         status_in = 1'b0;
         amount_in = req_word.change_cents;
         denom_in  = gcdisp_pkg::LAST_DENOM;
         if (idx_ok) begin
            if (req_word.op == gcdisp_pkg::OP_SET) begin
               stock_in[rd_idx] = load_sat;
            end else if (req_word.op == gcdisp_pkg::OP_DEPOSIT &&
                         stock_rd != gcdisp_pkg::COUNT_MAX) begin
               stock_in[rd_idx] = stock_rd + 1'b1;
            end
         end
      end
      case (state_ff)
         gcdisp_pkg::ST_DIV: fit_in = gcdisp_pkg::FIT_BITS'(quot);
         gcdisp_pkg::ST_SUB: begin
            take_in[denom_ff] = take_n;
            amount_in         = amount_ff - gcdisp_pkg::AMOUNT_BITS'(prod2);
            if (denom_ff != '0) begin
               denom_in = denom_ff - 1'b1;
            end
         end
         gcdisp_pkg::ST_COMMIT: begin
            if (amount_ff == '0) begin
               for (int d = 0; d < gcdisp_pkg::NUM_DENOMS; d++) begin
                  stock_in[d] = stock_ff[d] - gcdisp_pkg::COUNT_BITS'(take_ff[d]);
               end
            end else begin
               status_in = 1'b1;
               take_in   = '{default: '0};
            end
         end
         default: ;
      endcase
   end

   // Control and stock registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcdisp_pkg::ST_IDLE;
         stock_ff <= '{default: '0};
      end else begin
         state_ff <= state_in;
         stock_ff <= stock_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      take_ff   <= take_in;
      amount_ff <= amount_in;
      fit_ff    <= fit_in;
      denom_ff  <= denom_in;
      status_ff <= status_in;
   end

   // Response word
   always_comb begin
      rsp_word.status            = status_ff;
      rsp_word.five_cent_out     = gcdisp_pkg::OUT_BITS'(take_ff[0]);
      rsp_word.ten_cent_out      = gcdisp_pkg::OUT_BITS'(take_ff[1]);
      rsp_word.twenty_cent_out   = gcdisp_pkg::OUT_BITS'(take_ff[2]);
      rsp_word.fifty_cent_out    = gcdisp_pkg::OUT_BITS'(take_ff[3]);
      rsp_word.one_dollar_out    = gcdisp_pkg::OUT_BITS'(take_ff[4]);
      rsp_word.two_dollar_out    = gcdisp_pkg::OUT_BITS'(take_ff[5]);
      rsp_word.five_dollar_out   = gcdisp_pkg::OUT_BITS'(take_ff[6]);
      rsp_word.ten_dollar_out    = gcdisp_pkg::OUT_BITS'(take_ff[7]);
      rsp_word.twenty_dollar_out = gcdisp_pkg::OUT_BITS'(take_ff[8]);
      rsp_word.fifty_dollar_out  = gcdisp_pkg::OUT_BITS'(take_ff[9]);
   end

   // Assertions
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status |->
         rsp_word.five_cent_out == '0 && rsp_word.fifty_dollar_out == '0 &&
         rsp_word.one_dollar_out == '0 && rsp_word.ten_dollar_out == '0)
      else $error("failed dispense shows non-zero counts");

   a_short_op: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.op != gcdisp_pkg::OP_DISPENSE |=> rsp_valid)
      else $error("set/deposit response not on next cycle");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      state_ff == gcdisp_pkg::ST_SUB |->
         prod2 <= gcdisp_pkg::PROD2_BITS'(amount_ff))
      else $error("dispensed value exceeds remaining amount");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcdisp_pkg::ST_DIV || state_ff == gcdisp_pkg::ST_SUB) |->
         denom_ff <= gcdisp_pkg::LAST_DENOM)
      else $error("denomination walk out of range");

   a_commit_reply: assert property (@(posedge clock) disable iff (reset)
      state_ff == gcdisp_pkg::ST_COMMIT |=> rsp_valid && !busy)
      else $error("commit not followed by response");

endmodule
